// ----- hdl/rasum_pkg.sv -----
// Package: shared widths, codes and command types for the range-add/range-sum store.
`default_nettype none
package rasum_pkg;
    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int IDX_W   = 11;
    localparam int DATA_W  = 64;
    localparam int AMT_W   = 32;
    localparam int OP_W    = 2;
    localparam int CMP_W   = 17;
    localparam int CMD_ADDR_W = 16;

    localparam logic [IDX_W-1:0] ELEM_COUNT_RST = 11'd1024;

    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_LOAD = 2'd0;
    localparam t_op OP_ADD  = 2'd1;
    localparam t_op OP_SUM  = 2'd2;

    typedef logic [1:0] t_cmd_kind;
    localparam t_cmd_kind CMD_LOAD = 2'd0;
    localparam t_cmd_kind CMD_ADD  = 2'd1;
    localparam t_cmd_kind CMD_SUM  = 2'd2;
    localparam t_cmd_kind CMD_ZERO = 2'd3;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [CMD_ADDR_W-1:0]  lo;
        logic [CMD_ADDR_W-1:0]  hi;
        logic [DATA_W-1:0]      data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_back_stat;
endpackage
`default_nettype wire

// ----- hdl/rasum_ifs.sv -----
// Interfaces: input item channel and result channel.
`default_nettype none
interface rasum_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [10:0]        low_index;
    logic [10:0]        high_index;
    logic signed [63:0] load_value;
    logic signed [31:0] add_amount;
    modport source (output valid, operation, low_index, high_index, load_value, add_amount,
                    input ready);
    modport sink   (input valid, operation, low_index, high_index, load_value, add_amount,
                    output ready);
endinterface

interface rasum_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] range_sum;
    modport source (output valid, range_sum, input ready);
    modport sink   (input valid, range_sum, output ready);
endinterface
`default_nettype wire

// ----- hdl/range_add_range_sum_tree.sv -----
// Order: a load crosses the queue and is written when the idle back end pops it; an add
// sweeps S_RUN, S_DRAIN; a nonempty query S_RUN, S_DRAIN, S_OUT, an empty one S_OUT,
// where the sum waits until the result register frees up. Throughput: one item per
// back-end pass, set by the single memory read port swept one element a cycle; the
// queue holds two items. Reset: synchronous; a clearing pass zeroes all MAX_ELEMENTS
// entries, with input ready low throughout; element_count returns to 1024.
`default_nettype none
module range_add_range_sum_tree #(
    parameter int MAX_ELEMENTS = rasum_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [rasum_pkg::IDX_W-1:0] i_cfg_wdata,
    rasum_in_if.sink                         i_in,
    rasum_out_if.source                      o_out
);
    import rasum_pkg::*;

    logic [IDX_W-1:0] r_elem_count;
    t_cmd             push_cmd, head_cmd;
    logic             push, pop;
    t_fifo_stat       fifo_stat;
    t_back_stat       back_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= ELEM_COUNT_RST;
        end else if (i_cfg_we) begin
            r_elem_count <= i_cfg_wdata;
        end
    end

    rasum_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
        .i_in        (i_in),
        .i_elem_count(r_elem_count),
        .i_fifo_stat (fifo_stat),
        .i_back_stat (back_stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    rasum_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_cmd  (head_cmd),
        .o_stat (fifo_stat)
    );

    rasum_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (head_cmd),
        .i_fifo_stat(fifo_stat),
        .o_pop      (pop),
        .o_stat     (back_stat),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.clearing |-> !i_in.ready)
        else $error("input taken during clearing pass");
    a_fifo_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("queue both full and empty");
    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> back_stat.clearing)
        else $error("no clearing pass after reset");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fifo_stat.empty)
        else $error("pop from empty queue");
    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !back_stat.busy)
        else $error("pop while back end busy");
`endif
endmodule
`default_nettype wire

// ----- hdl/rasum_cmd_fifo.sv -----
// Two-entry command queue between front and back.
`default_nettype none
module rasum_cmd_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire rasum_pkg::t_cmd i_cmd,
    input  wire logic            i_pop,
    output rasum_pkg::t_cmd      o_cmd,
    output rasum_pkg::t_fifo_stat o_stat
);
    import rasum_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
endmodule
`default_nettype wire

// ----- hdl/rasum_front.sv -----
// Front end: accepts items, clips ranges and turns them into commands.
`default_nettype none
module rasum_front #(
    parameter int MAX_ELEMENTS = rasum_pkg::MAX_ELEMENTS_DEF
) (
    rasum_in_if.sink                       i_in,
    input  wire logic [rasum_pkg::IDX_W-1:0] i_elem_count,
    input  wire rasum_pkg::t_fifo_stat     i_fifo_stat,
    input  wire rasum_pkg::t_back_stat     i_back_stat,
    output logic                           o_push,
    output rasum_pkg::t_cmd                o_cmd
);
    import rasum_pkg::*;

    logic [CMP_W-1:0] top, a, b, a_c, b_c, ec;
    logic             load_ok, nonempty, take;

    assign i_in.ready = !i_fifo_stat.full && !i_back_stat.clearing;
    assign take = i_in.valid && i_in.ready;

    always_comb begin
        ec  = CMP_W'(i_elem_count);
        top = (ec < CMP_W'(MAX_ELEMENTS)) ? ec : CMP_W'(MAX_ELEMENTS);
        a   = CMP_W'(i_in.low_index);
        b   = CMP_W'(i_in.high_index);
        load_ok  = (a >= CMP_W'(1)) && (a <= top);
        a_c = (a < CMP_W'(1)) ? CMP_W'(1) : a;
        b_c = (b > top) ? top : b;
        nonempty = (a_c <= b_c);

        o_cmd.lo   = CMD_ADDR_W'(a_c - CMP_W'(1));
        o_cmd.hi   = CMD_ADDR_W'(b_c - CMP_W'(1));
        o_cmd.kind = CMD_ZERO;
        o_cmd.data = DATA_W'(signed'(i_in.add_amount));
        o_push     = 1'b0;
        unique case (i_in.operation)
            OP_LOAD: begin
                o_cmd.kind = CMD_LOAD;
                o_cmd.data = i_in.load_value;
                o_push     = take && load_ok;
            end
            OP_ADD: begin
                o_cmd.kind = CMD_ADD;
                o_push     = take && nonempty;
            end
            OP_SUM: begin
                o_cmd.kind = nonempty ? CMD_SUM : CMD_ZERO;
                o_push     = take;
            end
            default: begin
                // drop the unused code
                o_push = 1'b0;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/rasum_back.sv -----
// Back end: element memory, range sweep for add and sum, result register.
`default_nettype none
module rasum_back #(
    parameter int MAX_ELEMENTS = rasum_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rasum_pkg::t_cmd  i_cmd,
    input  wire rasum_pkg::t_fifo_stat i_fifo_stat,
    output logic                  o_pop,
    output rasum_pkg::t_back_stat o_stat,
    rasum_out_if.source           o_out
);
    import rasum_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(MAX_ELEMENTS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [DATA_W-1:0] r_mem [MAX_ELEMENTS];

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_clr, r_ptr, r_hi, r_p_addr;
    logic              r_p_vld, n_p_vld;
    t_cmd_kind         r_kind;
    logic [DATA_W-1:0] r_data, r_acc, r_rdata, r_out;
    logic              r_out_vld;

    logic              rd_en, we;
    logic [AW-1:0]     wa;
    logic [DATA_W-1:0] wd;
    logic              out_load;

    always_comb begin
        n_state  = r_state;
        n_p_vld  = 1'b0;
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        we       = 1'b0;
        wa       = r_p_addr;
        wd       = r_rdata + r_data;
        out_load = 1'b0;
        if (r_p_vld && r_kind == CMD_ADD) begin
            we = 1'b1;
        end
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                wa = r_clr;
                wd = '0;
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_fifo_stat.empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_LOAD: begin
                            we = 1'b1;
                            wa = i_cmd.lo[AW-1:0];
                            wd = i_cmd.data;
                        end
                        CMD_ZERO: n_state = S_OUT;
                        default:  n_state = S_RUN;
                    endcase
                end
            end
            S_RUN: begin
                rd_en   = 1'b1;
                n_p_vld = 1'b1;
                if (r_ptr == r_hi) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = (r_kind == CMD_SUM) ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                // hold the sum until the result register frees up
                if (!r_out_vld || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p_vld <= n_p_vld;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_cmd.kind;
            r_ptr  <= i_cmd.lo[AW-1:0];
            r_hi   <= i_cmd.hi[AW-1:0];
            r_data <= i_cmd.data;
            r_acc  <= '0;
        end else begin
            if (rd_en) begin
                r_ptr <= r_ptr + AW'(1);
            end
            if (r_p_vld && r_kind == CMD_SUM) begin
                r_acc <= r_acc + r_rdata;
            end
        end
        r_p_addr <= r_ptr;
        if (out_load) begin
            r_out <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.busy     = (r_state != S_IDLE);
    assign o_out.valid     = r_out_vld;
    assign o_out.range_sum = r_out;
endmodule
`default_nettype wire

// ----- tb/range_add_range_sum_tree_tb.sv -----
// Testbench for range_add_range_sum_tree: directed and random loads, range adds and queries.
`timescale 1ns / 1ps
`default_nettype none
module range_add_range_sum_tree_tb;
    import rasum_pkg::*;

    localparam int NELEM = 1024;
    localparam int LIMIT_CYCLES = 10000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [IDX_W-1:0] i_cfg_wdata;

    rasum_in_if  in_ch();
    rasum_out_if out_ch();

    range_add_range_sum_tree #(.MAX_ELEMENTS(NELEM)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    // Flat array mirror of the store.
    logic [63:0] elem_vals [1:NELEM];
    int unsigned elem_count;
    logic [63:0] sum_queue[$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    longint cycle_cnt = 0;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("range_add_range_sum_tree_tb: errors");
            $finish;
        end
    end

    // Receiver: drive ready at falling edge, check at rising edge.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (sum_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h",
                         $time, out_ch.range_sum);
                errors++;
            end else begin
                if (out_ch.range_sum !== sum_queue[0]) begin
                    $display("%0t: range_sum mismatch, expected %0h, actual %0h",
                             $time, sum_queue[0], out_ch.range_sum);
                    errors++;
                end
                void'(sum_queue.pop_front());
            end
        end
    end

    task automatic predict_item(input t_op op, input int unsigned lo, input int unsigned hi,
                                input logic [63:0] val, input logic [31:0] amt);
        int unsigned top;
        int unsigned a;
        int unsigned b;
        logic [63:0] acc;
        top = (elem_count < NELEM) ? elem_count : NELEM;
        acc = '0;
        if (op == OP_LOAD) begin
            if (lo >= 1 && lo <= top) elem_vals[lo] = val;
            return;
        end
        a = (lo < 1) ? 1 : lo;
        b = (hi > top) ? top : hi;
        if (op == OP_ADD) begin
            for (int i = a; i <= b; i++) elem_vals[i] += {{32{amt[31]}}, amt};
        end else if (op == OP_SUM) begin
            for (int i = a; i <= b; i++) acc += elem_vals[i];
            sum_queue.push_back(acc);
        end
    endtask

    // Leave valid high after the transaction; the next caller either sends or drops it.
    task automatic send_item(input t_op op, input int unsigned lo, input int unsigned hi,
                             input logic [63:0] val, input logic [31:0] amt);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.low_index  <= lo[10:0];
        in_ch.high_index <= hi[10:0];
        in_ch.load_value <= val;
        in_ch.add_amount <= amt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(op, lo, hi, val, amt);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every result, then for the back end to finish queued sweeps.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sum_queue.size() != 0) @(negedge i_clk);
        repeat (3 * NELEM + 40) @(negedge i_clk);
    endtask

    task automatic write_count(input int unsigned n);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n[10:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        elem_count = n & 11'h7FF;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly short ranges, occasionally wide ones.
    task automatic random_item();
        t_op op;
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        int unsigned r;
        r = $urandom_range(99);
        op = (r < 35) ? OP_LOAD : (r < 65) ? OP_ADD : (r < 97) ? OP_SUM : t_op'(3);
        span = ($urandom_range(19) == 0) ? $urandom_range(2047) : $urandom_range(40);
        lo = ($urandom_range(29) == 0) ? $urandom_range(2047) : $urandom_range(NELEM);
        hi = lo + span;
        if ($urandom_range(15) == 0) hi = $urandom_range(2047);
        send_item(op, lo, hi & 11'h7FF, rand64(), $urandom());
    endtask

    task automatic test_directed();
        send_item(OP_LOAD, 1, 0, 64'h7FFF_FFFF_FFFF_FFFF, '0);
        send_item(OP_LOAD, NELEM, 0, 64'h8000_0000_0000_0000, '0);
        send_item(OP_LOAD, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_item(OP_LOAD, 2047, 0, 64'h1234, '0);
        send_item(OP_SUM, 1, NELEM, '0, '0);
        send_item(OP_SUM, 0, 2047, '0, '0);
        send_item(OP_ADD, 1, 1, '0, 32'h7FFF_FFFF);
        send_item(OP_ADD, 0, 2047, '0, 32'h8000_0000);
        send_item(OP_ADD, 512, 2, '0, 32'h1);
        send_item(OP_SUM, 1, 1, '0, '0);
        send_item(OP_SUM, 5, 3, '0, '0);
        send_item(OP_SUM, 512, 513, '0, '0);
        send_item(t_op'(3), 1, NELEM, '1, '1);
        send_item(OP_SUM, NELEM, NELEM, '0, '0);
        send_item(OP_SUM, 1, NELEM, '0, '0);
    endtask

    task automatic test_count_settings();
        write_count(1);
        send_item(OP_LOAD, 2, 0, 64'h55, '0);
        send_item(OP_ADD, 1, 2047, '0, 32'h3);
        send_item(OP_SUM, 1, 2047, '0, '0);
        write_count(0);
        send_item(OP_ADD, 1, 10, '0, 32'h9);
        send_item(OP_SUM, 1, 10, '0, '0);
        write_count(2047);
        send_item(OP_SUM, 1, 2047, '0, '0);
        write_count(37);
        repeat (60) random_item();
        write_count(NELEM);
        send_item(OP_SUM, 1, NELEM, '0, '0);
    endtask

    task automatic test_random(input int n, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) random_item();
    endtask

    task automatic test_backpressure();
        hold_cycles <= 400;
        repeat (15) random_item();
        drain();
        repeat (10) random_item();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = '0;
        in_ch.low_index = '0;
        in_ch.high_index = '0;
        in_ch.load_value = '0;
        in_ch.add_amount = '0;
        out_ch.ready = 1'b0;
        for (int i = 1; i <= NELEM; i++) elem_vals[i] = '0;
        elem_count = NELEM;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_count_settings();
        test_random(320, 19, 67);
        test_random(320, 67, 19);
        test_random(300, 0, 0);
        test_backpressure();
        drain();
        if (errors == 0 && sum_queue.size() == 0) begin
            $display("range_add_range_sum_tree_tb: clean");
        end else begin
            $display("range_add_range_sum_tree_tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/rasum_pkg.sv
hdl/rasum_ifs.sv
hdl/rasum_cmd_fifo.sv
hdl/rasum_front.sv
hdl/rasum_back.sv
hdl/range_add_range_sum_tree.sv
tb/range_add_range_sum_tree_tb.sv
